### rtl/core/fpst_pkg.sv
// Package for the Fenwick prefix-sum table: transaction types, op codes, controller types.
package fpst_pkg;

  localparam int DATA_W          = 32;
  localparam int FIELD_W         = 11;
  localparam int MAX_ENTRIES_DEF = 1024;

  localparam logic [FIELD_W-1:0] CFG_SIZE_RESET = 11'd1024;

  // operation codes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_RANGE  = 2'd1;
  localparam logic [1:0] OP_POINT  = 2'd2;
  localparam logic [1:0] OP_PREFIX = 2'd3;

  // result status codes
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic [1:0]                operation;
    logic [FIELD_W-1:0]        position;
    logic signed [DATA_W-1:0]  delta;
    logic [FIELD_W-1:0]        range_low;
    logic [FIELD_W-1:0]        range_high;
  } fpst_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  sum;
    logic                      status;
  } fpst_res_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_DONE
  } fpst_state_t;

  // controller -> datapath
  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic load;
    logic walk;
    logic next_walk;
  } fpst_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic clr_last;
    logic walk_live;
    logic up_mode;
  } fpst_stat_t;

endpackage

### rtl/core/fenwick_prefix_sum_table.sv
// Top level of the Fenwick prefix-sum table: controller plus datapath.
//
//  channel   | handshake          | payload            | direction
//  ----------+--------------------+--------------------+----------
//  request   | start && !busy     | fpst_req_t request | in
//  result    | done (one cycle)   | fpst_res_t result  | out
//  config    | cfg_we             | cfg_wdata (size)   | in
//
// One request transaction is taken at a time. Walks visit one node per cycle,
// as the node memory has a single read port. Reset, and every size write,
// starts a clearing pass that zeroes the node memory one word a cycle; busy
// is high throughout. The receiver cannot stall: each result is shown on the
// done cycle only.
//
// Add walks climb from the position by the lowest set bit and write back
// node + delta; reads are pipelined so the write of one node overlaps the
// read of the next. Queries run prefix(a) then subtract prefix(b); the
// datapath clamps both bounds to the size in use at load time.
module fenwick_prefix_sum_table import fpst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fpst_req_t          request,
  output logic               done,
  output fpst_res_t          result,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata
);

  fpst_cmd_t  cmd;
  fpst_stat_t stat;

  fpst_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  fpst_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

endmodule

### rtl/core/fpst_datapath.sv
// Datapath: size register, node memory, walk index unit, accumulator and clear counter.
module fpst_datapath import fpst_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [FIELD_W-1:0] cfg_wdata,
  input  fpst_req_t          request,
  input  fpst_cmd_t          cmd,
  output fpst_stat_t         stat,
  output fpst_res_t          result
);

  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int WW  = (NW + 1 > FIELD_W + 1) ? NW + 1 : FIELD_W + 1;
  localparam int AW  = $clog2(MAX_ENTRIES);

  function automatic logic [WW-1:0] clamp(input logic [WW-1:0] x, input logic [WW-1:0] lim);
    return (x > lim) ? lim : x;
  endfunction

  logic [DATA_W-1:0] mem [MAX_ENTRIES];

  logic [FIELD_W-1:0]       cfg_size;
  logic [AW-1:0]            clr_cnt;
  logic [WW-1:0]            idx;
  logic [WW-1:0]            idx_b;
  logic                     up_mode;
  logic                     sub_mode;
  logic                     flag;
  logic signed [DATA_W-1:0] acc;
  logic signed [DATA_W-1:0] delta_r;
  logic [DATA_W-1:0]        rd_data;
  logic                     rd_pend;
  logic [AW-1:0]            rd_addr;

  logic [WW-1:0] size_n, cfg_ext, pos_ext, lo_ext, hi_ext, pos_m1, lo_m1;
  logic [WW-1:0] bound_a, bound_b, idx_m1, idx_up, idx_down;
  logic          load_flag, walk_live, issue, range_ok;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  always_comb begin
    cfg_ext  = WW'(cfg_size);
    size_n   = (cfg_ext > WW'(MAX_ENTRIES)) ? WW'(MAX_ENTRIES) : cfg_ext;
    pos_ext  = WW'(request.position);
    lo_ext   = WW'(request.range_low);
    hi_ext   = WW'(request.range_high);
    pos_m1   = (pos_ext == '0) ? '0 : pos_ext - WW'(1);
    lo_m1    = (lo_ext == '0) ? '0 : lo_ext - WW'(1);
    range_ok = (lo_ext <= hi_ext);
    load_flag = (request.operation == OP_ADD) && ((pos_ext == '0) || (pos_ext > size_n));

    case (request.operation)
      OP_ADD:   bound_a = pos_ext;
      OP_RANGE: bound_a = range_ok ? clamp(hi_ext, size_n) : '0;
      default:  bound_a = clamp(pos_ext, size_n);
    endcase

    case (request.operation)
      OP_RANGE: bound_b = range_ok ? clamp(lo_m1, size_n) : '0;
      OP_POINT: bound_b = clamp(pos_m1, size_n);
      default:  bound_b = '0;
    endcase
  end

  // walk index: up adds the lowest set bit, down clears it
  always_comb begin
    idx_m1    = idx - WW'(1);
    idx_up    = idx + (idx & (~idx + WW'(1)));
    idx_down  = idx & idx_m1;
    walk_live = !flag && (up_mode ? (idx <= size_n) : (idx != '0));
    issue     = cmd.walk && walk_live;
  end

  always_comb begin
    mem_we    = cmd.clr_step || (rd_pend && up_mode);
    mem_waddr = cmd.clr_step ? clr_cnt : rd_addr;
    mem_wdata = cmd.clr_step ? '0 : rd_data + DATA_W'(delta_r);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (issue) begin
      rd_data <= mem[idx_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_size <= CFG_SIZE_RESET;
      clr_cnt  <= '0;
      idx      <= '0;
      idx_b    <= '0;
      up_mode  <= 1'b0;
      sub_mode <= 1'b0;
      flag     <= 1'b0;
      rd_pend  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_size <= cfg_wdata;
      end
      if (cmd.clr_init) begin
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      rd_pend <= issue;
      if (cmd.load) begin
        idx      <= bound_a;
        idx_b    <= bound_b;
        up_mode  <= (request.operation == OP_ADD);
        sub_mode <= 1'b0;
        flag     <= load_flag;
      end else if (cmd.next_walk) begin
        idx      <= idx_b;
        sub_mode <= 1'b1;
      end else if (issue) begin
        idx <= up_mode ? idx_up : idx_down;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc     <= '0;
      delta_r <= request.delta;
    end else if (rd_pend && !up_mode) begin
      acc <= sub_mode ? acc - $signed(rd_data) : acc + $signed(rd_data);
    end
    if (issue) begin
      rd_addr <= idx_m1[AW-1:0];
    end
  end

  always_comb begin
    stat.clr_last  = (clr_cnt == AW'(MAX_ENTRIES - 1));
    stat.walk_live = walk_live;
    stat.up_mode   = up_mode;
    result.sum     = acc;
    result.status  = flag ? STATUS_IGNORED : STATUS_DONE;
  end

endmodule

### rtl/core/fpst_ctrl.sv
// Controller: state machine that sequences clearing, the two tree walks and the result strobe.
module fpst_ctrl import fpst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       cfg_we,
  input  fpst_stat_t stat,
  output fpst_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  fpst_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (stat.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_next = ST_WALK_A;
      end
      ST_WALK_A: begin
        if (!stat.walk_live) state_next = stat.up_mode ? ST_DONE : ST_WALK_B;
      end
      ST_WALK_B: begin
        if (!stat.walk_live) state_next = ST_DONE;
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
    // a size write rebuilds the table
    if (cfg_we) state_next = ST_CLEAR;
  end

  always_comb begin
    cmd.clr_init  = cfg_we;
    cmd.clr_step  = (state == ST_CLEAR) && !cfg_we;
    cmd.load      = (state == ST_IDLE) && start;
    cmd.walk      = (state == ST_WALK_A) || (state == ST_WALK_B);
    cmd.next_walk = (state == ST_WALK_A) && !stat.walk_live && !stat.up_mode;
    busy          = (state != ST_IDLE);
    done          = (state == ST_DONE);
  end

endmodule

### rtl/core/fpst_checker.sv
// Port-level checker for the Fenwick prefix-sum table, bound to the top level.
module fpst_checker import fpst_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input fpst_res_t          result,
  input logic               cfg_we
);

  // result strobe only while a transaction is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done without busy");

  // no result in the cycle right after an accept
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done) else $error("result too early");

  // block frees up right after a result
  a_free_after: assert property (@(posedge clk) disable iff (rst)
    (done && !cfg_we) |=> !busy) else $error("busy after result");

  // size write starts a clearing pass
  a_cfg_clear: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy) else $error("no clear after size write");

  // an ignored add reports zero
  a_ignored_zero: assert property (@(posedge clk) disable iff (rst)
    (done && (result.status == STATUS_IGNORED)) |-> (result.sum == '0))
    else $error("ignored add with nonzero sum");

endmodule

bind fenwick_prefix_sum_table fpst_checker u_fpst_checker (.*);

### verif/tb_fenwick_prefix_sum_table.sv
// Testbench for the Fenwick prefix-sum table: directed and random transactions, self-checking.
`timescale 1ns / 100ps

module tb_fenwick_prefix_sum_table;
  import fpst_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports. Every input is known from time zero.
  // ---------------------------------------------------------------------------
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  fpst_req_t          request   = '0;
  logic               cfg_we    = 1'b0;
  logic [FIELD_W-1:0] cfg_wdata = '0;
  logic               busy;
  logic               done;
  fpst_res_t          result;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  fenwick_prefix_sum_table i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the node memory and the size register.
  // Node k holds the sum of positions k - lowbit(k) + 1 .. k.
  // ---------------------------------------------------------------------------
  logic [DATA_W-1:0]  node_sum [1:TABLE_DEPTH];
  logic [FIELD_W-1:0] size_reg;

  // Results predicted at acceptance, oldest first; the block answers in order.
  fpst_res_t awaited_results[$];
  int unsigned mismatch_count = 0;

  // Sender pacing: while set, requests go back to back with no idle cycles.
  bit back_to_back = 1'b0;

  // Size the tree actually covers; sizes above the maximum act as the maximum.
  function automatic int unsigned table_span();
    return (32'(size_reg) > TABLE_DEPTH) ? TABLE_DEPTH : 32'(size_reg);
  endfunction

  // Prefix sum walking down by the lowest set bit; the bound clamps to the span.
  function automatic logic [DATA_W-1:0] prefix_total(input int unsigned bound);
    int unsigned k;
    logic [DATA_W-1:0] acc;
    k   = (bound > table_span()) ? table_span() : bound;
    acc = '0;
    while (k > 0) begin
      acc += node_sum[k];
      k   -= k & (~k + 1);
    end
    return acc;
  endfunction

  // Applies one accepted request to the predictor and returns its result.
  function automatic fpst_res_t fenwick_apply(input fpst_req_t req);
    fpst_res_t   res;
    int unsigned n;
    int unsigned k;
    int unsigned pos;
    int unsigned lo;
    int unsigned hi;
    int unsigned below;
    n          = table_span();
    pos        = 32'(req.position);
    lo         = 32'(req.range_low);
    hi         = 32'(req.range_high);
    res.sum    = '0;
    res.status = STATUS_DONE;
    case (req.operation)
      OP_ADD: begin
        // position 0 or past the span: flagged, tree untouched
        if (pos == 0 || pos > n) begin
          res.status = STATUS_IGNORED;
        end else begin
          k = pos;
          while (k <= n) begin
            node_sum[k] += req.delta;
            k           += k & (~k + 1);
          end
        end
      end
      OP_RANGE: begin
        // empty range gives zero; a low bound of 0 acts as 1
        if (lo <= hi) begin
          below   = (lo == 0) ? 0 : lo - 1;
          res.sum = prefix_total(hi) - prefix_total(below);
        end
      end
      OP_POINT: begin
        below   = (pos == 0) ? 0 : pos - 1;
        res.sum = prefix_total(pos) - prefix_total(below);
      end
      default: begin
        res.sum = prefix_total(pos);
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Random request generation. Most requests are well-formed: positions inside
  // the span with the edges and one past it mixed in. About one in ten is pure
  // noise with every field fully random (covers all 11 bits of each bound).
  // ---------------------------------------------------------------------------
  function automatic int unsigned pick_position(input int unsigned n);
    if (n == 0) begin
      return $urandom_range(0, 3);
    end
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return n;
      2:       return n + 1;
      default: return $urandom_range(1, n);
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  function automatic fpst_req_t random_request(input int unsigned n);
    fpst_req_t   req;
    int unsigned roll;
    int unsigned lo;
    int unsigned hi;
    req.operation  = 2'($urandom_range(0, 3));
    req.position   = FIELD_W'($urandom);
    req.delta      = $urandom;
    req.range_low  = FIELD_W'($urandom);
    req.range_high = FIELD_W'($urandom);
    if ($urandom_range(0, 9) == 0) begin
      return req;
    end
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      req.operation = OP_ADD;
    end else if (roll < 60) begin
      req.operation = OP_RANGE;
    end else if (roll < 80) begin
      req.operation = OP_POINT;
    end else begin
      req.operation = OP_PREFIX;
    end
    req.position = FIELD_W'(pick_position(n));
    req.delta    = pick_delta();
    lo           = pick_position(n);
    hi           = pick_position(n);
    // mostly ordered bounds, some deliberately empty ranges
    if (lo > hi && $urandom_range(0, 9) < 7) begin
      req.range_low  = FIELD_W'(hi);
      req.range_high = FIELD_W'(lo);
    end else begin
      req.range_low  = FIELD_W'(lo);
      req.range_high = FIELD_W'(hi);
    end
    return req;
  endfunction

  // ---------------------------------------------------------------------------
  // Mismatch reporting and the result checker. A result is accepted at the edge
  // that closes its done cycle; values read here are the pre-edge ones.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  always @(posedge clk) begin : check_results
    fpst_res_t want;
    if (!rst && done === 1'b1) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: sum %0d status %0b",
                                  result.sum, result.status));
      end else begin
        want = awaited_results.pop_front();
        if (result.sum !== want.sum) begin
          report_mismatch($sformatf("sum %0d, predicted %0d", result.sum, want.sum));
        end
        if (result.status !== want.status) begin
          report_mismatch($sformatf("status %0b, predicted %0b",
                                    result.status, want.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sending one transaction. Called at a rising edge. The random gap starts from
  // the previous acceptance, so idle cycles land on every step of the walk.
  // With no gap, start simply stays high: it is never dropped and raised in the
  // same step. The prediction is made at the accepting edge.
  // ---------------------------------------------------------------------------
  task automatic send_request(input fpst_req_t req);
    int unsigned gap;
    fpst_res_t   predicted;
    gap = back_to_back ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 31) == 0) begin
      back_to_back = !back_to_back;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    do @(posedge clk); while (busy !== 1'b0);
    predicted = fenwick_apply(req);
    awaited_results.insert(awaited_results.size(), predicted);
  endtask

  // Directed transaction: fields the operation ignores get random content.
  task automatic send_directed(input logic [1:0] op, input int unsigned pos,
                               input logic [DATA_W-1:0] delta,
                               input int unsigned lo, input int unsigned hi);
    fpst_req_t req;
    req.operation  = op;
    req.position   = FIELD_W'($urandom);
    req.delta      = $urandom;
    req.range_low  = FIELD_W'($urandom);
    req.range_high = FIELD_W'($urandom);
    case (op)
      OP_ADD: begin
        req.position = FIELD_W'(pos);
        req.delta    = delta;
      end
      OP_RANGE: begin
        req.range_low  = FIELD_W'(lo);
        req.range_high = FIELD_W'(hi);
      end
      default: begin
        req.position = FIELD_W'(pos);
      end
    endcase
    send_request(req);
  endtask

  // ---------------------------------------------------------------------------
  // Size register write. Only done with the block idle and every result in.
  // The write restarts the clearing pass, so we wait to see busy go high; the
  // next send then waits for it to drop.
  // ---------------------------------------------------------------------------
  task automatic write_table_size(input logic [FIELD_W-1:0] value);
    start <= 1'b0;
    while (awaited_results.size() != 0 || busy !== 1'b0) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    size_reg = value;
    foreach (node_sum[i]) node_sum[i] = '0;
    do @(posedge clk); while (busy !== 1'b1);
  endtask

  task automatic run_phase(input logic [FIELD_W-1:0] size_value, input int unsigned count);
    write_table_size(size_value);
    repeat (count) send_request(random_request(table_span()));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset size (full table): field extremes, flagged adds, clamped bounds,
  // empty ranges, position zero in each query, signed wrap of a node.
  task automatic test_reset_directed();
    send_directed(OP_ADD,    1,    32'h7FFF_FFFF, 0,    0);
    send_directed(OP_ADD,    1024, 32'h8000_0000, 0,    0);
    send_directed(OP_ADD,    0,    32'd5,         0,    0);
    send_directed(OP_ADD,    1025, 32'd7,         0,    0);
    send_directed(OP_ADD,    2047, 32'hFFFF_FFFF, 0,    0);
    send_directed(OP_ADD,    512,  32'hFFFF_FFFF, 0,    0);
    send_directed(OP_ADD,    1,    32'd1,         0,    0);  // node 1 wraps
    send_directed(OP_PREFIX, 0,    '0,            0,    0);
    send_directed(OP_PREFIX, 1,    '0,            0,    0);
    send_directed(OP_PREFIX, 511,  '0,            0,    0);
    send_directed(OP_PREFIX, 1024, '0,            0,    0);
    send_directed(OP_PREFIX, 2047, '0,            0,    0);
    send_directed(OP_RANGE,  0,    '0,            0,    1024);
    send_directed(OP_RANGE,  0,    '0,            1,    1);
    send_directed(OP_RANGE,  0,    '0,            5,    3);
    send_directed(OP_RANGE,  0,    '0,            2047, 0);
    send_directed(OP_RANGE,  0,    '0,            1024, 2047);
    send_directed(OP_RANGE,  0,    '0,            513,  1024);
    send_directed(OP_POINT,  0,    '0,            0,    0);
    send_directed(OP_POINT,  1,    '0,            0,    0);
    send_directed(OP_POINT,  512,  '0,            0,    0);
    send_directed(OP_POINT,  1024, '0,            0,    0);
    send_directed(OP_POINT,  1025, '0,            0,    0);
  endtask

  // Size extremes: one entry, none at all, all ones (above max), two entries.
  task automatic test_size_extremes();
    run_phase(11'd1,    120);
    run_phase(11'd0,    120);
    run_phase(11'd2047, 120);
    run_phase(11'd2,    120);
  endtask

  // Mixed traffic on full, small, odd and mid sizes.
  task automatic test_mixed_traffic();
    run_phase(11'd1024,                    300);
    run_phase(11'($urandom_range(3, 64)),  250);
    run_phase(11'd1023,                    250);
    run_phase(11'($urandom_range(65, 1022)), 200);
    run_phase(11'd1,                       100);
    run_phase(11'd1024,                    100);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    size_reg = CFG_SIZE_RESET;
    foreach (node_sum[i]) node_sum[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_directed();
    test_size_extremes();
    test_mixed_traffic();

    // drain: every result in, then a quiet stretch to catch strays
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (32) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run (clearing passes included).
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

### fenwick_prefix_sum_table.f
rtl/core/fpst_pkg.sv
rtl/core/fpst_datapath.sv
rtl/core/fpst_ctrl.sv
rtl/core/fenwick_prefix_sum_table.sv
rtl/core/fpst_checker.sv
verif/tb_fenwick_prefix_sum_table.sv
